// ----- hw/rtl/calm_pkg.sv -----
// shared types and constants of the card access list matcher
// no dependencies; imported by calm_cell, calm_chain and the top level
`default_nettype none

package calm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int UID_W       = 32;
    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 16;
    localparam int VERDICT_W   = 3;
    localparam int USED_W      = 7;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [UID_W-1:0]  MASTER_UID_RST = 32'hD3EC2B28;
    localparam logic [UID_W-1:0]  CLEAR_UID_RST  = 32'hB2C82C1B;
    localparam logic [HOLD_W-1:0] HOLDOFF_RST    = 16'd3000;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MASTER_UID = 2'd0,
        REG_CLEAR_UID  = 2'd1,
        REG_HOLDOFF    = 2'd2
    } t_reg_idx;

    typedef enum logic [VERDICT_W-1:0] {
        V_IGNORED   = 3'd0,
        V_GRANTED   = 3'd1,
        V_DENIED    = 3'd2,
        V_ARMED     = 3'd3,
        V_ENROLLED  = 3'd4,
        V_DUPLICATE = 3'd5,
        V_FULL      = 3'd6,
        V_CLEARED   = 3'd7
    } t_verdict;

    // search token that walks down the row of cells
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [CNT_W-1:0] left;
        logic [UID_W-1:0] uid;
    } t_probe;

endpackage

`default_nettype wire

// ----- hw/rtl/calm_cell.sv -----
// one table cell: holds one stored uid, compares a passing probe, shifts on insert
// depends on calm_pkg
`default_nettype none

module calm_cell
    import calm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_probe           i_probe,
    output t_probe                o_probe,
    input  wire logic             i_shift_en,
    input  wire logic [UID_W-1:0] i_shift_uid,
    output logic      [UID_W-1:0] o_uid
);

    logic             r_valid;
    logic             r_hit;
    logic [CNT_W-1:0] r_left;
    logic [UID_W-1:0] r_probe_uid;
    logic [UID_W-1:0] r_uid;
    logic             w_live;
    logic             w_match;

    // cells past the fill level are not compared
    assign w_live  = i_probe.left != '0;
    assign w_match = w_live && (r_uid == i_probe.uid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_probe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit       <= i_probe.hit | w_match;
        r_left      <= w_live ? i_probe.left - CNT_W'(1) : i_probe.left;
        r_probe_uid <= i_probe.uid;
        if (i_shift_en) begin
            r_uid <= i_shift_uid;
        end
    end

    assign o_probe.valid = r_valid;
    assign o_probe.hit   = r_hit;
    assign o_probe.left  = r_left;
    assign o_probe.uid   = r_probe_uid;
    assign o_uid         = r_uid;

endmodule

`default_nettype wire

// ----- hw/rtl/calm_chain.sv -----
// row of MAX_ENTRIES cells; newest entry in cell 0, insert shifts the row by one
// depends on calm_pkg and calm_cell
`default_nettype none

module calm_chain
    import calm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_probe           i_probe,
    output t_probe                o_probe,
    input  wire logic             i_shift_en,
    input  wire logic [UID_W-1:0] i_shift_uid
);

    t_probe           w_probe [MAX_ENTRIES+1];
    logic [UID_W-1:0] w_uid   [MAX_ENTRIES];

    assign w_probe[0] = i_probe;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        logic [UID_W-1:0] w_shift_in;
        if (k == 0) begin : g_head
            assign w_shift_in = i_shift_uid;
        end else begin : g_body
            assign w_shift_in = w_uid[k-1];
        end
        calm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_probe     (w_probe[k]),
            .o_probe     (w_probe[k+1]),
            .i_shift_en  (i_shift_en),
            .i_shift_uid (w_shift_in),
            .o_uid       (w_uid[k])
        );
    end

    assign o_probe = w_probe[MAX_ENTRIES];

endmodule

`default_nettype wire

// ----- hw/rtl/card_access_list_matcher_unit.sv -----
// card access list matcher: hold-off filter, master/clear cards, enrollment
// ignored, master, clear and full reads go straight to the done state; grant, deny, enroll and
// duplicate wait in the scan state until the probe has walked the row; done registers the result
// one read in flight at a time: a new read is accepted only while idle
// reset: synchronous active low; clears count, add mode, last time and loads register
// defaults; the uid cells are not cleared, the fill count masks them
`default_nettype none

module card_access_list_matcher_unit
    import calm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input beat
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [UID_W-1:0]     i_card_uid,
    input  wire logic [TIME_W-1:0]    i_time_ms,
    // result beat
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [VERDICT_W-1:0]      o_verdict,
    output logic [USED_W-1:0]         o_entries_used,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_armed, n_armed;
    logic [TIME_W-1:0]  r_last, n_last;
    logic               r_enroll, n_enroll;
    logic [UID_W-1:0]   r_uid, n_uid;
    t_verdict           r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_verdict           r_out_verdict, n_out_verdict;
    logic [USED_W-1:0]  r_out_used, n_out_used;
    logic [UID_W-1:0]   r_master;
    logic [UID_W-1:0]   r_clear;
    logic [HOLD_W-1:0]  r_holdoff;

    logic               w_accept;
    logic [TIME_W-1:0]  w_diff;
    logic               w_full;
    logic               w_launch;
    logic               w_shift;
    logic               w_cfg_wr;
    t_reg_idx           w_idx;
    t_probe             w_probe_in;
    t_probe             w_probe_out;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master  <= MASTER_UID_RST;
            r_clear   <= CLEAR_UID_RST;
            r_holdoff <= HOLDOFF_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_MASTER_UID: r_master  <= pwdata;
                REG_CLEAR_UID:  r_clear   <= pwdata;
                REG_HOLDOFF:    r_holdoff <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MASTER_UID: prdata = r_master;
            REG_CLEAR_UID:  prdata = r_clear;
            REG_HOLDOFF:    prdata = APB_DW'(r_holdoff);
            default:        prdata = '0;
        endcase
    end

    // datapath
    assign o_ready  = r_state == S_IDLE;
    assign w_accept = i_valid && o_ready;
    assign w_diff   = i_time_ms - r_last;
    assign w_full   = r_count == CNT_W'(MAX_ENTRIES);

    assign w_probe_in.valid = w_launch;
    assign w_probe_in.hit   = 1'b0;
    assign w_probe_in.left  = r_count;
    assign w_probe_in.uid   = i_card_uid;

    calm_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_probe     (w_probe_in),
        .o_probe     (w_probe_out),
        .i_shift_en  (w_shift),
        .i_shift_uid (r_uid)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_armed       = r_armed;
        n_last        = r_last;
        n_enroll      = r_enroll;
        n_uid         = r_uid;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_out_used    = r_out_used;
        w_launch      = 1'b0;
        w_shift       = 1'b0;

        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_uid   = i_card_uid;
                    n_state = S_DONE;
                    if (w_diff < TIME_W'(r_holdoff)) begin
                        n_pend = V_IGNORED;
                    end else begin
                        n_last = i_time_ms;
                        // master wins when both ids are equal
                        if (i_card_uid == r_master) begin
                            n_armed = 1'b1;
                            n_pend  = V_ARMED;
                        end else if (i_card_uid == r_clear) begin
                            n_count = '0;
                            n_armed = 1'b0;
                            n_pend  = V_CLEARED;
                        end else if (r_armed) begin
                            n_armed = 1'b0;
                            if (w_full) begin
                                n_pend = V_FULL;
                            end else begin
                                w_launch = 1'b1;
                                n_enroll = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end else begin
                            w_launch = 1'b1;
                            n_enroll = 1'b0;
                            n_state  = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_probe_out.valid) begin
                    n_state = S_DONE;
                    if (r_enroll) begin
                        if (w_probe_out.hit) begin
                            n_pend = V_DUPLICATE;
                        end else begin
                            w_shift = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_pend  = V_ENROLLED;
                        end
                    end else begin
                        n_pend = w_probe_out.hit ? V_GRANTED : V_DENIED;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_pend;
                    n_out_used    = USED_W'(r_count);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_armed     <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_armed     <= n_armed;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_enroll      <= n_enroll;
        r_uid         <= n_uid;
        r_pend        <= n_pend;
        r_out_verdict <= n_out_verdict;
        r_out_used    <= n_out_used;
    end

    assign o_valid        = r_out_valid;
    assign o_verdict      = r_out_verdict;
    assign o_entries_used = r_out_used;

    // a probe leaves the row only while a scan is waiting for it
    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe_out.valid |-> r_state == S_SCAN)
        else $error("probe left the cell row outside a scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_shift_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> !w_full && r_enroll)
        else $error("insert into a full table or outside enrollment");

    // an enrollment scan either adds one entry or leaves the count alone; this checks the insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not bump the entry count");

endmodule

`default_nettype wire
